[rtl/pli_pkg.sv]
`default_nettype none
package pli_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 11;

    localparam logic [1:0] OP_WR_WAVE = 2'd0;
    localparam logic [1:0] OP_WR_RESP = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    // one classified item as queued from front to back
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] point_index;
        logic [31:0] point_value;
        logic [31:0] query_wavelength;
    } pli_item_t;

    localparam int ITEM_W = $bits(pli_item_t);

endpackage
`default_nettype wire

[rtl/pli_ram.sv]
`default_nettype none
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[rtl/pli_fifo.sv]
`default_nettype none
module pli_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [WIDTH-1:0] out_data
);

    // two-entry queue
    logic [WIDTH-1:0] slot_reg [2];
    logic             wptr_reg, rptr_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

[rtl/pli_front.sv]
`default_nettype none
module pli_front (
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [75:0]           s_tdata,
    output logic                       q_valid,
    input  wire logic                  q_ready,
    output pli_pkg::pli_item_t         q_item
);

    // unpack only; unused opcodes pass through and the back end answers them with a plain no-op result
    assign s_tready = q_ready;
    assign q_valid  = s_tvalid;

    always_comb
    begin
        q_item.opcode           = s_tdata[1:0];
        q_item.point_index      = {6'd0, s_tdata[11:2]};
        q_item.point_value      = s_tdata[43:12];
        q_item.query_wavelength = s_tdata[75:44];
    end

endmodule
`default_nettype wire

[rtl/pli_back.sv]
`default_nettype none
module pli_back #(
    parameter int MAX_POINTS = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [pli_pkg::COUNT_W-1:0]    point_count,
    input  wire logic                           q_valid,
    output logic                                q_ready,
    input  wire pli_pkg::pli_item_t             q_item,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [31:0]                    m_tdata,
    output logic                                m_tuser
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_FIRST = 7'b0000010,
        S_LAST  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_MUL   = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg;
    logic [NW-1:0]  n_reg;
    logic [NW-1:0]  idx_reg;
    logic signed [31:0] q_reg, wl_reg, w0_reg, rl_reg;
    logic [63:0]    prod_reg;
    logic [32:0]    den_reg;
    logic [33:0]    rem_reg;
    logic [63:0]    quo_reg;
    logic [6:0]     bit_reg;
    logic           neg_reg;
    logic [32:0]    mag_reg;
    logic [32:0]    dx_reg;
    logic [1:0]     mstep_reg;
    logic [31:0]    res_reg;
    logic           found_reg;
    logic           out_v_reg;

    logic           we_w, we_r;
    logic [AW-1:0]  raddr;
    logic [31:0]    w_rd, r_rd;
    logic [NW-1:0]  n_cap;
    logic           take;

    assign take = q_valid && q_ready;
    assign q_ready = (state_reg == S_IDLE) && !out_v_reg;
    assign we_w = take && q_item.opcode == pli_pkg::OP_WR_WAVE
        && 32'(q_item.point_index) < 32'(MAX_POINTS);
    assign we_r = take && q_item.opcode == pli_pkg::OP_WR_RESP
        && 32'(q_item.point_index) < 32'(MAX_POINTS);

    always_comb
    begin
        n_cap = (32'(point_count) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS)
                                                      : NW'(point_count);
        raddr = idx_reg[AW-1:0];
    end

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_wave (
        .clk(clk), .we(we_w), .waddr(q_item.point_index[AW-1:0]),
        .wdata(q_item.point_value), .raddr(raddr), .rdata(w_rd));
    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_resp (
        .clk(clk), .we(we_r), .waddr(q_item.point_index[AW-1:0]),
        .wdata(q_item.point_value), .raddr(raddr), .rdata(r_rd));

    assign m_tvalid = out_v_reg;
    assign m_tdata  = res_reg;
    assign m_tuser  = found_reg;

    // scan: idx_reg addresses entry i; the ram read is registered, so use a wait bit
    logic           wait_reg;
    logic [33:0]    rsh;
    logic [63:0]    mul_part;

    always_comb
    begin
        rsh = {rem_reg[32:0], prod_reg[bit_reg[5:0]]};
        mul_part = 64'(mag_reg[15:0]) * 64'(dx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            idx_reg   <= '0;
            wait_reg  <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            if (out_v_reg && m_tready)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        res_reg   <= '0;
                        found_reg <= 1'b0;
                        q_reg     <= q_item.query_wavelength;
                        n_reg     <= n_cap;
                        if (q_item.opcode == pli_pkg::OP_QUERY && n_cap >= NW'(2))
                        begin
                            idx_reg   <= '0;
                            wait_reg  <= 1'b1;
                            state_reg <= S_FIRST;
                        end
                        else
                        begin
                            out_v_reg <= 1'b1;
                        end
                    end
                end
                S_FIRST:
                begin
                    if (wait_reg)
                    begin
                        wait_reg <= 1'b0;
                    end
                    else
                    begin
                        w0_reg    <= w_rd;
                        idx_reg   <= n_reg - NW'(1);
                        wait_reg  <= 1'b1;
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (wait_reg)
                    begin
                        wait_reg <= 1'b0;
                    end
                    else
                    begin
                        if (q_reg < w0_reg || q_reg > $signed(w_rd))
                        begin
                            out_v_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            wait_reg  <= 1'b1;
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (wait_reg)
                    begin
                        wait_reg <= 1'b0;
                    end
                    else if (idx_reg == '0 && !found_reg && bit_reg != 7'd1)
                    begin
                        // first entry captured as left side
                        wl_reg  <= w_rd;
                        rl_reg  <= r_rd;
                        bit_reg <= 7'd1;
                        idx_reg <= NW'(1);
                        wait_reg <= 1'b1;
                    end
                    else
                    begin
                        if (wl_reg <= q_reg && $signed(w_rd) > q_reg)
                        begin
                            neg_reg <= ($signed(r_rd) < rl_reg);
                            mag_reg <= ($signed(r_rd) < rl_reg)
                                ? 33'({rl_reg[31], rl_reg} - {r_rd[31], r_rd})
                                : 33'({r_rd[31], r_rd} - {rl_reg[31], rl_reg});
                            dx_reg  <= 33'({q_reg[31], q_reg} - {wl_reg[31], wl_reg});
                            den_reg <= 33'({w_rd[31], w_rd} - {wl_reg[31], wl_reg});
                            prod_reg  <= '0;
                            mstep_reg <= 2'd0;
                            state_reg <= S_MUL;
                        end
                        else if (idx_reg + NW'(1) >= n_reg)
                        begin
                            bit_reg   <= 7'd0;
                            out_v_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            wl_reg   <= w_rd;
                            rl_reg   <= r_rd;
                            idx_reg  <= idx_reg + NW'(1);
                            wait_reg <= 1'b1;
                        end
                    end
                end
                S_MUL:
                begin
                    // 16-bit slices of the magnitude, three partial products
                    prod_reg  <= prod_reg + (mul_part << (16 * mstep_reg));
                    mag_reg   <= mag_reg >> 16;
                    mstep_reg <= mstep_reg + 2'd1;
                    if (mstep_reg == 2'd2)
                    begin
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        bit_reg   <= 7'd63;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rsh >= {1'b0, den_reg})
                    begin
                        rem_reg <= rsh - {1'b0, den_reg};
                        quo_reg <= {quo_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh;
                        quo_reg <= {quo_reg[62:0], 1'b0};
                    end
                    if (bit_reg == 7'd0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        bit_reg <= bit_reg - 7'd1;
                    end
                end
                S_DONE:
                begin
                    res_reg   <= neg_reg ? rl_reg - quo_reg[31:0] : rl_reg + quo_reg[31:0];
                    found_reg <= 1'b1;
                    out_v_reg <= 1'b1;
                    bit_reg   <= 7'd0;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[rtl/piecewise_linear_interpolator_unit.sv]
`default_nettype none
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tdata: opcode, point_index, point_value, query_wavelength
// m_axis    out  m_tvalid/m_tready  m_tdata: result_response; m_tuser: segment_found
// apb       in   psel/penable       point_count at address 0
// a write or a miss ends without the multiply and divide; a query scans the table
// entry by entry (registered ram read), then runs 3 multiply steps and a 64-step divide
// reset is asynchronous active low and clears control and point_count only
// a two-entry queue between front and back lets either side stall on its own
module piecewise_linear_interpolator_unit #(
    parameter int MAX_POINTS = pli_pkg::MAX_POINTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // opcode, point_index, point_value, query_wavelength
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // result_response
    output logic             m_tuser,   // segment_found
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [pli_pkg::COUNT_W-1:0] count_reg;
    logic f_valid, f_ready, b_valid, b_ready;
    pli_pkg::pli_item_t f_item, b_item;
    logic [pli_pkg::ITEM_W-1:0] b_raw;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {21'd0, count_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            count_reg <= pwdata[pli_pkg::COUNT_W-1:0];
        end
    end

    pli_front u_front (
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata[75:0]),
        .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item));

    pli_fifo #(.WIDTH(pli_pkg::ITEM_W)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(f_valid), .in_ready(f_ready), .in_data(f_item),
        .out_valid(b_valid), .out_ready(b_ready), .out_data(b_raw));

    assign b_item = b_raw;

    pli_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .clk(clk), .rst_n(rst_n), .point_count(count_reg),
        .q_valid(b_valid), .q_ready(b_ready), .q_item(b_item),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser));

endmodule
`default_nettype wire

[tb/piecewise_linear_interpolator_unit_checker.sv]
`timescale 1ns / 1ps
module piecewise_linear_interpolator_unit_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [79:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic        m_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    input  wire logic        pready,
    output int               fail_count,
    output int               pending
);

    localparam logic [1:0] ADDR_POINT_COUNT = 2'd0;

    typedef struct packed {
        logic [31:0] response;
        logic        found;
    } interp_result_t;

    logic [31:0]    wave_tbl [pli_pkg::MAX_POINTS_DEF];
    logic [31:0]    resp_tbl [pli_pkg::MAX_POINTS_DEF];
    logic [10:0]    count_reg;
    interp_result_t expected_results [$];

    function automatic interp_result_t interpolate_item(logic [1:0] op, logic [9:0] idx,
                                                       logic [31:0] val, logic [31:0] qw);
        interp_result_t r;
        int           n;
        longint       q, wl, wr, a, b, dy, mag, dx, den, res;
        logic [127:0] prod, quo;
        r = '0;
        q = longint'($signed(qw));
        if (op == pli_pkg::OP_WR_WAVE) wave_tbl[idx] = val;
        else if (op == pli_pkg::OP_WR_RESP) resp_tbl[idx] = val;
        else if (op == pli_pkg::OP_QUERY)
        begin
            n = (count_reg > pli_pkg::MAX_POINTS_DEF) ? pli_pkg::MAX_POINTS_DEF
                                                       : int'(count_reg);
            if (n >= 2 && q >= longint'($signed(wave_tbl[0]))
                && q <= longint'($signed(wave_tbl[n-1])))
            begin
                for (int i = 0; i + 1 < n; i++)
                begin
                    wl = longint'($signed(wave_tbl[i]));
                    wr = longint'($signed(wave_tbl[i+1]));
                    if (wl <= q && wr > q)
                    begin
                        a    = longint'($signed(resp_tbl[i]));
                        b    = longint'($signed(resp_tbl[i+1]));
                        dy   = b - a;
                        mag  = (dy < 0) ? -dy : dy;
                        dx   = q - wl;
                        den  = wr - wl;
                        prod = 128'(mag) * 128'(dx);
                        quo  = prod / 128'(den);
                        res  = (dy < 0) ? a - longint'(quo[63:0]) : a + longint'(quo[63:0]);
                        r.response = res[31:0];
                        r.found    = 1'b1;
                        break;
                    end
                end
            end
        end
        return r;
    endfunction

    assign pending = expected_results.size();

    always @(posedge clk or negedge rst_n)
    begin
        interp_result_t e;
        if (!rst_n)
        begin
            count_reg  <= '0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == ADDR_POINT_COUNT)
                count_reg <= pwdata[10:0];
            if (s_tvalid && s_tready)
                expected_results.push_back(interpolate_item(s_tdata[1:0], s_tdata[11:2],
                                                            s_tdata[43:12], s_tdata[75:44]));
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: response %h found %b",
                                 m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.response !== m_tdata || e.found !== m_tuser)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected response %h found %b, got %h %b",
                                     e.response, e.found, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

[tb/piecewise_linear_interpolator_unit_tb.sv]
`timescale 1ns / 1ps
module piecewise_linear_interpolator_unit_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] ADDR_POINT_COUNT = 2'd0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_req = 0;
    int          wave_copy [pli_pkg::MAX_POINTS_DEF];

    piecewise_linear_interpolator_unit dut (.*);

    piecewise_linear_interpolator_unit_checker u_checker (.*);

    always #5 clk = ~clk;

    initial
    begin
        #30ms;
        $display("piecewise_linear_interpolator_unit_tb: errors");
        $finish;
    end

    // receiver back-pressure, with one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0) hold_left = 400;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0) hold_req = 0;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(logic [1:0] op, logic [9:0] idx, logic [31:0] val,
                             logic [31:0] qw);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, qw, val, idx, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_count(logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_POINT_COUNT;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_point(int i, int w, int r);
        wave_copy[i] = w;
        send_item(pli_pkg::OP_WR_WAVE, i[9:0], w, $urandom);
        send_item(pli_pkg::OP_WR_RESP, i[9:0], r, $urandom);
    endtask

    // a query aimed at the table, picked among the interesting places
    task automatic send_query(int n);
        int     k;
        longint lo, hi, q;
        k = (n > 1) ? $urandom_range(n - 2) : 0;
        case ($urandom_range(7))
            0: q = wave_copy[k];
            1: q = wave_copy[n-1];
            2: q = longint'(wave_copy[0]) - $urandom_range(1, 50);
            3: q = longint'(wave_copy[n-1]) + $urandom_range(1, 50);
            4: q = $signed($urandom);
            default:
            begin
                lo = wave_copy[k];
                hi = (n > 1) ? wave_copy[k+1] : lo;
                q  = (hi > lo) ? lo + longint'({$urandom, $urandom} % (hi - lo + 1)) : lo;
            end
        endcase
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        send_item(pli_pkg::OP_QUERY, 10'($urandom), $urandom, q[31:0]);
    endtask

    // builds a table of n points, usually sorted, sometimes not
    task automatic load_table(int n);
        int     base, step;
        int     mode;
        longint w;
        mode = $urandom_range(9);
        base = $signed($urandom) >>> 1;
        step = $urandom_range(1, 5000);
        for (int i = 0; i < n; i++)
        begin
            if (mode == 0) w = $signed($urandom);
            else if (mode == 1) w = base + (i / 2) * step;
            else w = longint'(base) + longint'(i) * step;
            write_point(i, int'(w), $urandom);
        end
    endtask

    initial
    begin
        int n, pick;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: widest span with extreme responses
        write_point(0, 32'sh8000_0000, 32'sh7fff_ffff);
        write_point(1, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(pli_pkg::OP_QUERY, 10'h3ff, 32'hffff_ffff, 32'h0);
        send_item(OP_UNUSED, 10'h3ff, 32'hffff_ffff, 32'hffff_ffff);
        wait_drain();
        write_count(2);
        send_item(pli_pkg::OP_QUERY, 10'h3ff, 32'hffff_ffff, 32'h0);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h8000_0000);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h7fff_ffff);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h7fff_fffe);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h8000_0001);
        send_item(OP_UNUSED, '0, '0, '0);
        write_point(1023, 32'h1234_5678, 32'h8765_4321);
        wait_drain();
        write_count(1);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0);
        wait_drain();
        write_count(0);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0);
        // query below the first point, above the last, inside and on the last on a small sorted table
        write_point(0, 32'h0001_0000, 32'h0000_0000);
        write_point(1, 32'h0002_0000, 32'h0010_0000);
        write_point(2, 32'h0002_0000, 32'h0020_0000);
        wait_drain();
        write_count(3);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0000_ffff);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0002_0001);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0001_8000);
        send_item(pli_pkg::OP_QUERY, '0, '0, 32'h0002_0000);
        wait_drain();

        // random part, phase by phase
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int seg = 0; seg < 5; seg++)
            begin
                pick = $urandom_range(9);
                n = (pick == 0) ? $urandom_range(1) : $urandom_range(2, 10);
                load_table((n < 2) ? 2 : n);
                wait_drain();
                write_count(n);
                if (ph == 0 && seg == 1) hold_req = 1;
                for (int j = 0; j < 16; j++)
                begin
                    pick = $urandom_range(19);
                    if (pick == 0)
                        send_item(OP_UNUSED, 10'($urandom), $urandom, $urandom);
                    else if (pick == 1)
                        // write above the active points, never read back
                        send_item(2'($urandom_range(1)), 10'($urandom_range(n + 1, 1023)),
                                  $urandom, $urandom);
                    else
                        send_query((n < 2) ? 2 : n);
                end
                wait_drain();
            end
        end
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("piecewise_linear_interpolator_unit_tb: clean");
        else
            $display("piecewise_linear_interpolator_unit_tb: errors");
        $finish;
    end
endmodule

[filelist.f]
rtl/pli_pkg.sv
rtl/pli_ram.sv
rtl/pli_fifo.sv
rtl/pli_front.sv
rtl/pli_back.sv
rtl/piecewise_linear_interpolator_unit.sv
tb/piecewise_linear_interpolator_unit_checker.sv
tb/piecewise_linear_interpolator_unit_tb.sv
